/* rtl/scpf_pkg.sv */
`default_nettype none
package scpf_pkg;

	localparam int COORD_BITS = 24;
	localparam int MAX_POINTS = 64;
	localparam int ADDR_BITS  = $clog2(MAX_POINTS);
	localparam int CNT_BITS   = ADDR_BITS + 1;
	localparam int SUM_BITS   = 31;              // signed sum of z
	localparam int SMAG_BITS  = 30;              // |sum of z| <= 2^29
	localparam int SQ_BITS    = 53;              // sum of z squared
	localparam int THR_BITS   = 12;
	localparam logic [THR_BITS-1:0] THR_RESET = 12'd256;
	localparam int T2_BITS    = 2 * THR_BITS;
	localparam int VAR_BITS   = 60;              // n*Q and S^2 both below 2^59
	localparam int HALF_BITS  = VAR_BITS / 2;
	localparam int PART_BITS  = HALF_BITS + T2_BITS;
	localparam int RIGHT_BITS = VAR_BITS + T2_BITS;
	localparam int D_BITS     = 32;              // n*z - S, signed
	localparam int DMAG_BITS  = 31;
	localparam int LEFT_BITS  = 2 * DMAG_BITS + 16;
	localparam int ITEM_BITS  = 3 * COORD_BITS;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // store point, accumulate
		logic drop;       // point beyond capacity
		logic calc1;      // n*Q, S^2, T^2
		logic calc2;      // variance term
		logic calc3;      // split products with T^2
		logic calc4;      // right-hand side sum
		logic idx_clr;
		logic idx_inc;
		logic rd;         // read store at index
		logic diff;       // n*z - S
		logic sq;         // squared deviation
		logic push_pend;  // pending point to output, not last
		logic take_pend;  // current point becomes pending
		logic fin;        // final result, clear set
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic full;
		logic keep;
		logic pend_v;
		logic idx_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/sigma_clip_point_filter_top.sv */
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata {z,y,x}, tlast = last point of set
// m_*       out  m_tvalid/m_tready  tdata {z,y,x}, tlast = last result,
//                                   tuser {overflowed, point_valid}
// thresh_*  in   thresh_we          threshold in sigmas, unsigned Q4.8
//
// Load: one point per cycle, s_tready high the whole load phase.
// After the closing point: CALC1 to CALC4 form n*Q - S^2 times T^2, then a
// scan steps through each stored point (store read, n*z - S, square, compare)
// and waits while the output stalls. One result register sits on the output side.
// arst_n clears counts, sums, flags and the threshold (1.0); the store is not
// cleared, only entries of the current set are ever read.
`default_nettype none
module sigma_clip_point_filter_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [scpf_pkg::ITEM_BITS-1:0]       s_tdata,  // point_x, point_y, point_z
	input  wire                                  s_tlast,  // last_point
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [scpf_pkg::ITEM_BITS-1:0]       m_tdata,  // kept_x, kept_y, kept_z
	output logic                                 m_tlast,  // last_result
	output logic [1:0]                           m_tuser,  // point_valid, overflowed
	input  wire                                  thresh_we,
	input  wire  [scpf_pkg::THR_BITS-1:0]        thresh_wdata
);

	scpf_pkg::cmd_t cmd;
	scpf_pkg::sts_t sts;
	logic           pv, ovf;

	// sequencing: load, bound computation, scan, end of set
	scpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, accumulators, exact sigma test, pending and output registers
	scpf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.thr_we    (thresh_we),
		.thr_wdata (thresh_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_pv    (pv),
		.out_ovf   (ovf)
	);

	assign m_tuser = {ovf, pv};

endmodule
`default_nettype wire

/* rtl/scpf_ctrl.sv */
`default_nettype none
module scpf_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_last,
	output logic              in_ready,
	input  scpf_pkg::sts_t    sts,
	output scpf_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_LOAD, ST_CALC1, ST_CALC2, ST_CALC3, ST_CALC4,
		ST_RD, ST_DIFF, ST_SQ, ST_TEST, ST_FIN
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == ST_LOAD);
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load = acc && !sts.full;
				cmd.drop = acc && sts.full;
				if (acc && in_last) begin
					state_d = ST_CALC1;
				end
			end
			ST_CALC1: begin
				cmd.calc1 = 1'b1;
				state_d   = ST_CALC2;
			end
			ST_CALC2: begin
				cmd.calc2 = 1'b1;
				state_d   = ST_CALC3;
			end
			ST_CALC3: begin
				cmd.calc3 = 1'b1;
				state_d   = ST_CALC4;
			end
			ST_CALC4: begin
				cmd.calc4   = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = ST_RD;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_TEST;
			end
			ST_TEST: begin
				// a kept point waits while the pending one cannot move out
				if (!(sts.keep && sts.pend_v && !sts.out_free)) begin
					cmd.push_pend = sts.keep && sts.pend_v;
					cmd.take_pend = sts.keep;
					if (sts.idx_last) begin
						state_d = ST_FIN;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_RD;
					end
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/scpf_datapath.sv */
`default_nettype none
module scpf_datapath (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  scpf_pkg::cmd_t                        cmd,
	output scpf_pkg::sts_t                        sts,
	input  wire  [scpf_pkg::ITEM_BITS-1:0]        in_data,
	input  wire                                   thr_we,
	input  wire  [scpf_pkg::THR_BITS-1:0]         thr_wdata,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [scpf_pkg::ITEM_BITS-1:0]        out_data,
	output logic                                  out_last,
	output logic                                  out_pv,
	output logic                                  out_ovf
);

	localparam int CB = scpf_pkg::COORD_BITS;

	// point store: {z, y, x}
	logic [scpf_pkg::ITEM_BITS-1:0] mem [scpf_pkg::MAX_POINTS];

	logic [scpf_pkg::THR_BITS-1:0]   thr_q;
	logic [scpf_pkg::CNT_BITS-1:0]   count_q;
	logic signed [scpf_pkg::SUM_BITS-1:0] sum_q;
	logic [scpf_pkg::SQ_BITS-1:0]    sumsq_q;
	logic                            ovf_q;

	logic [scpf_pkg::VAR_BITS-1:0]   nq_q, ss_q, var_q;
	logic [scpf_pkg::T2_BITS-1:0]    t2_q;
	logic [scpf_pkg::PART_BITS-1:0]  rlo_q, rhi_q;
	logic [scpf_pkg::RIGHT_BITS-1:0] right_q;

	logic [scpf_pkg::ADDR_BITS-1:0]  idx_q;
	logic [scpf_pkg::ITEM_BITS-1:0]  rd_q;
	logic signed [scpf_pkg::D_BITS-1:0] d_q;
	logic [scpf_pkg::LEFT_BITS-1:0]  left_q;

	logic [scpf_pkg::ITEM_BITS-1:0]  pend_q;
	logic                            pend_v_q;

	logic                            out_v_q;
	logic [scpf_pkg::ITEM_BITS-1:0]  out_d_q;
	logic                            out_last_q, out_pv_q, out_ovf_q;

	// load-side arithmetic
	logic signed [CB-1:0]            in_z;
	logic [CB-1:0]                   in_zmag;
	logic [2*CB-1:0]                 in_zsq;
	logic [scpf_pkg::SMAG_BITS-1:0]  smag;

	// scan-side arithmetic
	logic signed [CB-1:0]            rd_z;
	logic signed [scpf_pkg::D_BITS-1:0] d_prod;
	logic [scpf_pkg::DMAG_BITS-1:0]  dmag;
	logic                            out_free;

	assign in_z    = in_data[3*CB-1:2*CB];
	assign in_zmag = in_z[CB-1] ? CB'(-in_z) : CB'(in_z);
	assign in_zsq  = (2*CB)'(in_zmag) * (2*CB)'(in_zmag);
	assign smag    = sum_q[scpf_pkg::SUM_BITS-1] ? scpf_pkg::SMAG_BITS'(-sum_q)
	                                             : scpf_pkg::SMAG_BITS'(sum_q);

	assign rd_z    = rd_q[3*CB-1:2*CB];
	assign d_prod  = scpf_pkg::D_BITS'($signed({1'b0, count_q})) * scpf_pkg::D_BITS'(rd_z);
	assign dmag    = d_q[scpf_pkg::D_BITS-1] ? scpf_pkg::DMAG_BITS'(-d_q)
	                                         : scpf_pkg::DMAG_BITS'(d_q);

	assign out_free = !out_v_q || out_ready;

	assign sts.full     = (count_q == scpf_pkg::CNT_BITS'(scpf_pkg::MAX_POINTS));
	assign sts.keep     = ({(scpf_pkg::RIGHT_BITS - scpf_pkg::LEFT_BITS)'(0), left_q}
	                       <= right_q);
	assign sts.pend_v   = pend_v_q;
	assign sts.idx_last = ({1'b0, idx_q} + scpf_pkg::CNT_BITS'(1)) == count_q;
	assign sts.out_free = out_free;

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;
	assign out_last  = out_last_q;
	assign out_pv    = out_pv_q;
	assign out_ovf   = out_ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[count_q[scpf_pkg::ADDR_BITS-1:0]] <= in_data;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q];
		end
	end

	// threshold and per-set accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= scpf_pkg::THR_RESET;
			count_q <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (thr_we) begin
				thr_q <= thr_wdata;
			end
			if (cmd.fin) begin
				count_q <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (cmd.load) begin
					count_q <= count_q + scpf_pkg::CNT_BITS'(1);
					sum_q   <= sum_q + scpf_pkg::SUM_BITS'(in_z);
					sumsq_q <= sumsq_q + scpf_pkg::SQ_BITS'(in_zsq);
				end
				if (cmd.drop) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// bound computation and scan arithmetic
	always_ff @(posedge clk) begin
		if (cmd.calc1) begin
			nq_q <= scpf_pkg::VAR_BITS'(count_q) * scpf_pkg::VAR_BITS'(sumsq_q);
			ss_q <= scpf_pkg::VAR_BITS'(smag) * scpf_pkg::VAR_BITS'(smag);
			t2_q <= scpf_pkg::T2_BITS'(thr_q) * scpf_pkg::T2_BITS'(thr_q);
		end
		if (cmd.calc2) begin
			var_q <= (nq_q >= ss_q) ? (nq_q - ss_q) : '0;
		end
		if (cmd.calc3) begin
			rlo_q <= scpf_pkg::PART_BITS'(var_q[scpf_pkg::HALF_BITS-1:0])
			       * scpf_pkg::PART_BITS'(t2_q);
			rhi_q <= scpf_pkg::PART_BITS'(var_q[scpf_pkg::VAR_BITS-1:scpf_pkg::HALF_BITS])
			       * scpf_pkg::PART_BITS'(t2_q);
		end
		if (cmd.calc4) begin
			right_q <= scpf_pkg::RIGHT_BITS'(rlo_q)
			         + (scpf_pkg::RIGHT_BITS'(rhi_q) << scpf_pkg::HALF_BITS);
		end
		if (cmd.diff) begin
			d_q <= d_prod - scpf_pkg::D_BITS'(sum_q);
		end
		if (cmd.sq) begin
			left_q <= {(2*scpf_pkg::DMAG_BITS)'(dmag) * (2*scpf_pkg::DMAG_BITS)'(dmag),
			           16'h0000};
		end
		if (cmd.take_pend) begin
			pend_q <= rd_q;
		end
		if (cmd.push_pend) begin
			out_d_q    <= pend_q;
			out_last_q <= 1'b0;
			out_pv_q   <= 1'b1;
			out_ovf_q  <= ovf_q;
		end else if (cmd.fin) begin
			out_d_q    <= pend_v_q ? pend_q : '0;
			out_last_q <= 1'b1;
			out_pv_q   <= pend_v_q;
			out_ovf_q  <= ovf_q;
		end
	end

	// scan control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + scpf_pkg::ADDR_BITS'(1);
			end
			if (cmd.fin) begin
				pend_v_q <= 1'b0;
			end else if (cmd.take_pend) begin
				pend_v_q <= 1'b1;
			end
			if (cmd.push_pend || cmd.fin) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/scpf_checker.sv */
`default_nettype none
module scpf_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_tvalid,
	input wire                                 s_tready,
	input wire                                 s_tlast,
	input wire                                 m_tvalid,
	input wire                                 m_tready,
	input wire [scpf_pkg::ITEM_BITS-1:0]       m_tdata,
	input wire                                 m_tlast,
	input wire [1:0]                           m_tuser
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	else $error("stalled result changed");

	// empty marker only ends a set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
	else $error("empty marker without last");

	// empty marker carries zero coordinates
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
	else $error("empty marker with data");

	// closing point stops input while the set is filtered
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
	else $error("input taken after closing point");

endmodule

bind sigma_clip_point_filter_top scpf_checker u_scpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
